/* rtl/upc_pkg.sv */
// Shared types, constants and helpers for the URL percent codec.
package upc_pkg;

  // Codec modes; any other code acts as decode.
  localparam logic [1:0] MODE_FORM   = 2'd0;
  localparam logic [1:0] MODE_PATH   = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  // Register map (byte addresses).
  localparam int          ADDR_W         = 3;
  localparam logic [ADDR_W-1:0] ADDR_CODEC_MODE = 3'd0;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Work descriptor kinds passed from front to back.
  typedef enum logic {
    KIND_SINGLE = 1'b0,  // one word: data, last, bad as given
    KIND_ESCAPE = 1'b1   // three words: '%', high hex digit, low hex digit
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic       bad;
  } job_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    return (v > 4'd9) ? w + 8'd55 : w + 8'd48;
  endfunction

endpackage

/* rtl/upc_front.sv */
// Front end: accept input bytes, track decode escapes, emit work descriptors.
module upc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        mode,
  input  logic              cfg_clear,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push,
  output upc_pkg::job_t     job,
  input  logic              queue_full
);

  upc_pkg::esc_phase_t phase, phase_next;
  logic [3:0]          high_nibble, high_nibble_next;
  logic                accept;
  logic                emit;
  logic [4:0]          hex_val;

  function automatic logic passes(input logic [7:0] c, input logic path);
    logic alnum;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A);
    return alnum || c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h7E ||
           (path && (c == 8'h2F || c == 8'h3A));
  endfunction

  // 0..15, or 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    return 5'd16;
  endfunction

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign hex_val  = hex_value(in_byte);
  assign push     = accept && emit;

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    emit             = 1'b1;
    job.kind         = upc_pkg::KIND_SINGLE;
    job.data         = in_byte;
    job.last         = in_last;
    job.bad          = 1'b0;
    if (mode == upc_pkg::MODE_FORM || mode == upc_pkg::MODE_PATH) begin
      if (passes(in_byte, mode == upc_pkg::MODE_PATH)) begin
        job.data = in_byte;
      end else if (in_byte == upc_pkg::CHAR_SPACE) begin
        job.data = upc_pkg::CHAR_PLUS;
      end else begin
        job.kind = upc_pkg::KIND_ESCAPE;
      end
    end else if (phase == upc_pkg::ESC_IDLE) begin
      if (in_byte == upc_pkg::CHAR_PERCENT) begin
        if (in_last) begin
          job.data = 8'd0;
          job.bad  = 1'b1;
        end else begin
          emit       = 1'b0;
          phase_next = upc_pkg::ESC_HIGH;
        end
      end else if (in_byte == upc_pkg::CHAR_PLUS) begin
        job.data = upc_pkg::CHAR_SPACE;
      end
    end else if (hex_val[4]) begin
      // Not a hex digit: drop the escape, flag one error word.
      job.data         = 8'd0;
      job.bad          = 1'b1;
      phase_next       = upc_pkg::ESC_IDLE;
      high_nibble_next = 4'd0;
    end else if (phase == upc_pkg::ESC_HIGH) begin
      if (in_last) begin
        job.data         = 8'd0;
        job.bad          = 1'b1;
        phase_next       = upc_pkg::ESC_IDLE;
        high_nibble_next = 4'd0;
      end else begin
        emit             = 1'b0;
        high_nibble_next = hex_val[3:0];
        phase_next       = upc_pkg::ESC_LOW;
      end
    end else begin
      job.data         = {high_nibble, hex_val[3:0]};
      phase_next       = upc_pkg::ESC_IDLE;
      high_nibble_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      phase       <= upc_pkg::ESC_IDLE;
      high_nibble <= 4'd0;
    end else if (accept) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

endmodule

/* rtl/upc_queue.sv */
// Small FIFO of work descriptors between front and back.
module upc_queue #(
  parameter int DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upc_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output upc_pkg::job_t rdata,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upc_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/upc_back.sv */
// Back end: expand jobs into output words, one word per ready cycle.
module upc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  upc_pkg::job_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_bad
);

  upc_pkg::job_t cur;
  logic          cur_valid;
  logic [1:0]    beat;
  logic          last_beat;
  logic          done;

  assign last_beat = (cur.kind == upc_pkg::KIND_SINGLE) || (beat == 2'd2);
  assign done      = out_ready && last_beat;
  assign q_pop     = !q_empty && (!cur_valid || done);
  assign out_valid = cur_valid;

  always_comb begin
    out_byte = cur.data;
    out_last = cur.last;
    out_bad  = cur.bad;
    if (cur.kind == upc_pkg::KIND_ESCAPE) begin
      out_bad  = 1'b0;
      out_last = cur.last && (beat == 2'd2);
      case (beat)
        2'd0:    out_byte = upc_pkg::CHAR_PERCENT;
        2'd1:    out_byte = upc_pkg::hex_digit(cur.data[7:4]);
        default: out_byte = upc_pkg::hex_digit(cur.data[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat      <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      beat      <= 2'd0;
    end else if (cur_valid && out_ready) begin
      if (last_beat) begin
        cur_valid <= 1'b0;
        beat      <= 2'd0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

endmodule

/* rtl/url_percent_codec.sv */
// Top level of the URL percent codec: register port, front, queue and back.
//
// Use: bytes of a string enter on the s_ stream (tdata = byte, tlast marks
// the final byte). Converted words leave on the m_ stream (tdata = byte,
// tlast = final word of the string, tuser = bad escape flag). The codec_mode
// register at byte address 0 selects form encode, path encode or decode;
// write it only while the block is idle, which also drops any pending escape.
//
// An accepted byte is written into the descriptor queue and then loaded into
// the back end's descriptor register when it is free, which raises m_tvalid.
// Throughput: the back end sends one word per cycle while m_tready is high;
// a passed or decoded byte gives one word, an escaped byte three (the '%' and
// two hex digits). Decoding an escape takes three input bytes for one word.
// Bytes that open an escape only update the front end and send nothing.
//
// The front accepts while the descriptor queue has room, so it keeps taking
// bytes while an output word waits; a stalled receiver holds the current
// word steady and backs up the queue until s_tready drops.
// Reset clears the mode to form encode, the escape state, queue and output.
module url_percent_codec #(
  parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [upc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] in_byte
  input  logic                       s_tlast,   // in_last
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] out_byte
  output logic                       m_tlast,   // out_last
  output logic                       m_tuser    // [0] bad_escape
);

  logic [1:0]    codec_mode;
  logic          mode_write;
  logic          push, pop, q_full, q_empty;
  upc_pkg::job_t push_job, pop_job;

  // Register port: always ready, one register; word address is paddr[2].
  assign pready     = 1'b1;
  assign mode_write = psel && penable && pwrite && pready &&
                      (paddr[upc_pkg::ADDR_W-1:2] == upc_pkg::ADDR_CODEC_MODE[upc_pkg::ADDR_W-1:2]);
  assign prdata     = (paddr[upc_pkg::ADDR_W-1:2] ==
                       upc_pkg::ADDR_CODEC_MODE[upc_pkg::ADDR_W-1:2]) ?
                      {30'd0, codec_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= upc_pkg::MODE_FORM;
    end else if (mode_write) begin
      codec_mode <= pwdata[1:0];
    end
  end

  // Classify bytes and track the decode escape.
  upc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (codec_mode),
    .cfg_clear  (mode_write),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .push       (push),
    .job        (push_job),
    .queue_full (q_full)
  );

  // Decouple front from back so each side stalls on its own.
  upc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .full  (q_full),
    .pop   (pop),
    .rdata (pop_job),
    .empty (q_empty)
  );

  // Expand each descriptor into one or three output words.
  upc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_job),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_bad   (m_tuser)
  );

endmodule

/* rtl/upc_checker.sv */
// Port-level assertions for the URL percent codec, bound to the top level.
module upc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                              $stable(m_tlast) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // Error words carry a zero byte.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("error word with nonzero byte");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Input accepted just after reset cannot appear on the same edge.
  a_no_bypass: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && s_tvalid && s_tready |=> !m_tvalid)
    else $error("word appeared one edge after first accept");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
